FILE: rtl/pcapdf_pkg.sv
`timescale 1ns / 1ps

package pcapdf_pkg;

    localparam int unsigned SEARCH_LIMIT_DEF = 4096;
    localparam logic [31:0] MAX_PKT_RESET    = 32'd262144;

    localparam logic [31:0] MAGIC_US_BE = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_US_LE = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NS_BE = 32'ha1b23c4d;
    localparam logic [31:0] MAGIC_NS_LE = 32'h4d3cb2a1;

    localparam logic [4:0] FILE_HDR_FIRST = 5'd4;
    localparam logic [4:0] VERSION_POS    = 5'd7;
    localparam logic [4:0] HALVES_END     = 5'd8;
    localparam logic [4:0] SNAP_POS       = 5'd19;
    localparam logic [4:0] LINK_POS       = 5'd23;

    localparam logic [3:0] SECONDS_POS  = 4'd3;
    localparam logic [3:0] FRACTION_POS = 4'd7;
    localparam logic [3:0] LENGTH_POS   = 4'd11;
    localparam logic [3:0] REC_LAST_POS = 4'd15;

    typedef enum logic [1:0] {
        PH_SEARCH   = 2'd0,
        PH_FILE_HDR = 2'd1,
        PH_REC_HDR  = 2'd2,
        PH_PAYLOAD  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        K_SEARCH        = 4'd0,
        K_FILE_HDR      = 4'd1,
        K_FILE_HDR_DONE = 4'd2,
        K_REC_HDR       = 4'd3,
        K_REC_HDR_DONE  = 4'd4,
        K_PAYLOAD       = 4'd5,
        K_PAYLOAD_LAST  = 4'd6,
        K_ERROR         = 4'd7,
        K_IGNORED       = 4'd8,
        K_FINISH        = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE        = 3'd0,
        E_NO_MAGIC    = 3'd1,
        E_BAD_LENGTH  = 3'd2,
        E_FAILED      = 3'd3,
        E_NO_HEADER   = 3'd4,
        E_TRUNCATED   = 3'd5
    } t_err;

    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        t_err        error_code;
        logic        little_endian;
        logic        nanosecond;
        logic [31:0] version;
        logic [31:0] snap_length;
        logic [31:0] link_type;
        logic [31:0] ts_seconds;
        logic [31:0] ts_fraction;
        logic [31:0] included_length;
        logic [31:0] original_length;
    } t_result;

endpackage

FILE: rtl/pcapdf_parse.sv
`timescale 1ns / 1ps

module pcapdf_parse #(
    parameter int unsigned SEARCH_LIMIT = pcapdf_pkg::SEARCH_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_func,
    input  logic [7:0]          i_byte,
    input  logic [31:0]         i_max_pkt,
    output pcapdf_pkg::t_result o_result
);
    import pcapdf_pkg::*;

    localparam int unsigned CNT_W = $clog2(SEARCH_LIMIT + 2);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(SEARCH_LIMIT);

    t_phase           r_phase, n_phase;
    logic [23:0]      r_win, n_win;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [4:0]       r_pos, n_pos;
    logic             r_little, n_little;
    logic             r_nano, n_nano;
    logic [31:0]      r_version, n_version;
    logic [31:0]      r_snap, n_snap;
    logic [31:0]      r_link, n_link;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_sec, n_sec;
    logic [31:0]      r_frac, n_frac;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_left, n_left;
    logic             r_failed, n_failed;

    logic [31:0] cand;
    logic [1:0]  lane;
    logic [31:0] acc_new;
    logic [3:0]  rpos;
    t_kind       kind;
    t_err        err;
    logic [31:0] orig;
    logic [7:0]  echo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_win     <= '0;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_little  <= 1'b0;
            r_nano    <= 1'b0;
            r_version <= '0;
            r_snap    <= '0;
            r_link    <= '0;
            r_acc     <= '0;
            r_sec     <= '0;
            r_frac    <= '0;
            r_len     <= '0;
            r_left    <= '0;
            r_failed  <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_win     <= n_win;
            r_cnt     <= n_cnt;
            r_pos     <= n_pos;
            r_little  <= n_little;
            r_nano    <= n_nano;
            r_version <= n_version;
            r_snap    <= n_snap;
            r_link    <= n_link;
            r_acc     <= n_acc;
            r_sec     <= n_sec;
            r_frac    <= n_frac;
            r_len     <= n_len;
            r_left    <= n_left;
            r_failed  <= n_failed;
        end
    end

    always_comb begin
        cand = {r_win, i_byte};
        rpos = r_pos[3:0];
        if (r_phase == PH_FILE_HDR && r_pos < HALVES_END) begin
            lane = {~r_pos[1], r_little ? r_pos[0] : ~r_pos[0]};
        end else begin
            lane = r_little ? r_pos[1:0] : ~r_pos[1:0];
        end
        acc_new = ((r_pos[1:0] == 2'd0) ? 32'd0 : r_acc)
                | ({24'd0, i_byte} << {lane, 3'b000});

        n_phase   = r_phase;
        n_win     = r_win;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_little  = r_little;
        n_nano    = r_nano;
        n_version = r_version;
        n_snap    = r_snap;
        n_link    = r_link;
        n_acc     = r_acc;
        n_sec     = r_sec;
        n_frac    = r_frac;
        n_len     = r_len;
        n_left    = r_left;
        n_failed  = r_failed;
        kind      = K_SEARCH;
        err       = E_NONE;
        orig      = '0;
        echo      = i_byte;

        if (i_func == FUNC_FINISH) begin
            kind = K_FINISH;
            echo = '0;
            if (r_failed) begin
                err = E_FAILED;
            end else if (r_phase == PH_SEARCH || r_phase == PH_FILE_HDR) begin
                err = E_NO_HEADER;
            end else if (r_phase == PH_PAYLOAD || r_pos != 5'd0) begin
                err = E_TRUNCATED;
            end
        end else if (r_failed) begin
            kind = K_IGNORED;
            err  = E_FAILED;
        end else begin
            unique case (r_phase)
                PH_SEARCH: begin
                    n_win = cand[23:0];
                    if (r_cnt <= LIMIT) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (cand == MAGIC_US_BE || cand == MAGIC_US_LE ||
                        cand == MAGIC_NS_BE || cand == MAGIC_NS_LE) begin
                        n_little = (cand == MAGIC_US_LE || cand == MAGIC_NS_LE);
                        n_nano   = (cand == MAGIC_NS_BE || cand == MAGIC_NS_LE);
                        n_phase  = PH_FILE_HDR;
                        n_pos    = FILE_HDR_FIRST;
                        kind     = K_FILE_HDR;
                    end else if (n_cnt > LIMIT) begin
                        n_failed = 1'b1;
                        kind     = K_ERROR;
                        err      = E_NO_MAGIC;
                    end
                end
                PH_FILE_HDR: begin
                    kind  = K_FILE_HDR;
                    n_acc = acc_new;
                    if (r_pos == VERSION_POS) n_version = acc_new;
                    if (r_pos == SNAP_POS)    n_snap    = acc_new;
                    if (r_pos >= LINK_POS) begin
                        n_link  = acc_new;
                        kind    = K_FILE_HDR_DONE;
                        n_phase = PH_REC_HDR;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
                PH_REC_HDR: begin
                    kind  = K_REC_HDR;
                    n_acc = acc_new;
                    if (rpos == SECONDS_POS)  n_sec  = acc_new;
                    if (rpos == FRACTION_POS) n_frac = acc_new;
                    if (rpos == LENGTH_POS)   n_len  = acc_new;
                    if (rpos == REC_LAST_POS) begin
                        n_pos = '0;
                        if (r_len > i_max_pkt || (r_snap != 32'd0 && r_len > r_snap)) begin
                            n_failed = 1'b1;
                            kind     = K_ERROR;
                            err      = E_BAD_LENGTH;
                        end else begin
                            orig    = acc_new;
                            kind    = K_REC_HDR_DONE;
                            n_left  = r_len;
                            n_phase = (r_len != 32'd0) ? PH_PAYLOAD : PH_REC_HDR;
                        end
                    end else begin
                        n_pos = 5'(rpos) + 5'd1;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_left != 32'd0) n_left = r_left - 32'd1;
                    if (n_left == 32'd0) begin
                        kind    = K_PAYLOAD_LAST;
                        n_phase = PH_REC_HDR;
                        n_pos   = '0;
                    end else begin
                        kind = K_PAYLOAD;
                    end
                end
                default: begin
                    n_phase = PH_SEARCH;
                end
            endcase
        end

        o_result.kind            = kind;
        o_result.out_byte        = echo;
        o_result.error_code      = err;
        o_result.little_endian   = n_little;
        o_result.nanosecond      = n_nano;
        o_result.version         = n_version;
        o_result.snap_length     = n_snap;
        o_result.link_type       = n_link;
        o_result.ts_seconds      = n_sec;
        o_result.ts_fraction     = n_frac;
        o_result.included_length = n_len;
        o_result.original_length = orig;
    end

endmodule

FILE: rtl/pcap_stream_deframer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_func, i_in_byte
// out       source     o_out_valid / i_out_stall o_kind .. o_original_length
// cfg       sink       i_cfg_wr_en               i_cfg_wr_data (max packet size)
//
// One beat per cycle sustained while the output is not stalled; a beat passes
// through the input register, then the parse logic into the result register.
// Synchronous active-low reset returns the parser to magic search and the
// max packet size to 262144.
// A stall on the output holds the result and, once the input register is
// also full, raises o_in_stall.

module pcap_stream_deframer_core #(
    parameter int unsigned SEARCH_LIMIT = pcapdf_pkg::SEARCH_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_error_code,
    output logic        o_little_endian,
    output logic        o_nanosecond,
    output logic [31:0] o_version,
    output logic [31:0] o_snap_length,
    output logic [31:0] o_link_type,
    output logic [31:0] o_ts_seconds,
    output logic [31:0] o_ts_fraction,
    output logic [31:0] o_included_length,
    output logic [31:0] o_original_length,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);
    import pcapdf_pkg::*;

    logic        r_in_valid;
    logic        r_func;
    logic [7:0]  r_byte;
    logic        r_out_valid;
    t_result     r_res;
    t_result     result;
    logic [31:0] r_max_pkt;
    logic        step;

    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pkt <= MAX_PKT_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_pkt <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= i_func;
            r_byte <= i_in_byte;
        end
    end

    pcapdf_parse #(
        .SEARCH_LIMIT (SEARCH_LIMIT)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_func    (r_func),
        .i_byte    (r_byte),
        .i_max_pkt (r_max_pkt),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_res.kind;
    assign o_out_byte        = r_res.out_byte;
    assign o_error_code      = r_res.error_code;
    assign o_little_endian   = r_res.little_endian;
    assign o_nanosecond      = r_res.nanosecond;
    assign o_version         = r_res.version;
    assign o_snap_length     = r_res.snap_length;
    assign o_link_type       = r_res.link_type;
    assign o_ts_seconds      = r_res.ts_seconds;
    assign o_ts_fraction     = r_res.ts_fraction;
    assign o_included_length = r_res.included_length;
    assign o_original_length = r_res.original_length;

endmodule

FILE: sim/pcap_stream_deframer_core_tb.sv
`timescale 1ns / 1ps

module pcap_stream_deframer_core_tb;
    import pcapdf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PRINT_LIMIT    = 100;
    localparam int unsigned SRCH_LIMIT     = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = FUNC_DATA;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_error_code;
    logic        o_little_endian;
    logic        o_nanosecond;
    logic [31:0] o_version;
    logic [31:0] o_snap_length;
    logic [31:0] o_link_type;
    logic [31:0] o_ts_seconds;
    logic [31:0] o_ts_fraction;
    logic [31:0] o_included_length;
    logic [31:0] o_original_length;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'h0;

    // parser shadow state
    logic [31:0] max_size = MAX_PKT_RESET;
    logic [23:0] srch_win = '0;
    int unsigned srch_count = 0;
    t_phase      parse_phase = PH_SEARCH;
    logic [4:0]  hdr_pos = '0;
    logic        stream_little = 1'b0;
    logic        stream_nano = 1'b0;
    logic [31:0] ver_q = '0;
    logic [31:0] snap_q = '0;
    logic [31:0] link_q = '0;
    logic [31:0] word_acc = '0;
    logic [31:0] rec_secs = '0;
    logic [31:0] rec_frac = '0;
    logic [31:0] rec_len = '0;
    logic [31:0] bytes_left = '0;
    logic        stream_failed = 1'b0;

    t_result     frame_results_q[$];
    t_result     head_result;
    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned results_taken = 0;
    int unsigned stall_seen = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    bit          fast = 1'b0;
    bit          noise_on = 1'b0;

    pcap_stream_deframer_core #(
        .SEARCH_LIMIT (SRCH_LIMIT)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_out_byte        (o_out_byte),
        .o_error_code      (o_error_code),
        .o_little_endian   (o_little_endian),
        .o_nanosecond      (o_nanosecond),
        .o_version         (o_version),
        .o_snap_length     (o_snap_length),
        .o_link_type       (o_link_type),
        .o_ts_seconds      (o_ts_seconds),
        .o_ts_fraction     (o_ts_fraction),
        .o_included_length (o_included_length),
        .o_original_length (o_original_length),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_magic(logic [31:0] w);
        return w == MAGIC_US_BE || w == MAGIC_US_LE || w == MAGIC_NS_BE || w == MAGIC_NS_LE;
    endfunction

    function automatic void add_word(logic [7:0] b, logic [1:0] k);
        if (k == 2'd0) word_acc = '0;
        word_acc |= 32'(b) << (stream_little ? 8 * k : 8 * (3 - k));
    endfunction

    function automatic t_result parse_beat(logic func, logic [7:0] b);
        t_result     r;
        logic [31:0] cand;
        logic [4:0]  p;
        int unsigned sh;
        r = '0;
        r.out_byte = b;
        if (func == FUNC_FINISH) begin
            r.kind = K_FINISH;
            r.out_byte = 8'h00;
            if (stream_failed) r.error_code = E_FAILED;
            else if (parse_phase == PH_SEARCH || parse_phase == PH_FILE_HDR)
                r.error_code = E_NO_HEADER;
            else if (parse_phase == PH_PAYLOAD || hdr_pos != 0) r.error_code = E_TRUNCATED;
            else r.error_code = E_NONE;
        end else if (stream_failed) begin
            r.kind = K_IGNORED;
            r.error_code = E_FAILED;
        end else begin
            case (parse_phase)
                PH_SEARCH: begin
                    cand = {srch_win, b};
                    srch_win = cand[23:0];
                    if (srch_count <= SRCH_LIMIT) srch_count++;
                    if (is_magic(cand)) begin
                        stream_little = (cand == MAGIC_US_LE || cand == MAGIC_NS_LE);
                        stream_nano = (cand == MAGIC_NS_BE || cand == MAGIC_NS_LE);
                        parse_phase = PH_FILE_HDR;
                        hdr_pos = FILE_HDR_FIRST;
                        r.kind = K_FILE_HDR;
                    end else if (srch_count > SRCH_LIMIT) begin
                        stream_failed = 1'b1;
                        r.kind = K_ERROR;
                        r.error_code = E_NO_MAGIC;
                    end else begin
                        r.kind = K_SEARCH;
                    end
                end
                PH_FILE_HDR: begin
                    p = hdr_pos;
                    r.kind = K_FILE_HDR;
                    if (p < HALVES_END) begin
                        if (p[1:0] == 2'd0) word_acc = '0;
                        sh = (p[1] ? 0 : 16) + (stream_little ? (p[0] ? 8 : 0) : (p[0] ? 0 : 8));
                        word_acc |= 32'(b) << sh;
                    end else begin
                        add_word(b, p[1:0]);
                    end
                    if (p == VERSION_POS) ver_q = word_acc;
                    if (p == SNAP_POS) snap_q = word_acc;
                    if (p >= LINK_POS) begin
                        link_q = word_acc;
                        r.kind = K_FILE_HDR_DONE;
                        parse_phase = PH_REC_HDR;
                        hdr_pos = '0;
                    end else begin
                        hdr_pos = p + 5'd1;
                    end
                end
                PH_REC_HDR: begin
                    p = {1'b0, hdr_pos[3:0]};
                    r.kind = K_REC_HDR;
                    add_word(b, p[1:0]);
                    if (p[3:0] == SECONDS_POS) rec_secs = word_acc;
                    if (p[3:0] == FRACTION_POS) rec_frac = word_acc;
                    if (p[3:0] == LENGTH_POS) rec_len = word_acc;
                    if (p[3:0] == REC_LAST_POS) begin
                        hdr_pos = '0;
                        if (rec_len > max_size || (snap_q != 0 && rec_len > snap_q)) begin
                            stream_failed = 1'b1;
                            r.kind = K_ERROR;
                            r.error_code = E_BAD_LENGTH;
                        end else begin
                            r.kind = K_REC_HDR_DONE;
                            r.original_length = word_acc;
                            bytes_left = rec_len;
                            parse_phase = (rec_len != 0) ? PH_PAYLOAD : PH_REC_HDR;
                        end
                    end else begin
                        hdr_pos = p + 5'd1;
                    end
                end
                default: begin
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) begin
                        r.kind = K_PAYLOAD_LAST;
                        parse_phase = PH_REC_HDR;
                        hdr_pos = '0;
                    end else begin
                        r.kind = K_PAYLOAD;
                    end
                end
            endcase
        end
        r.little_endian = stream_little;
        r.nanosecond = stream_nano;
        r.version = ver_q;
        r.snap_length = snap_q;
        r.link_type = link_q;
        r.ts_seconds = rec_secs;
        r.ts_fraction = rec_frac;
        r.included_length = rec_len;
        return r;
    endfunction

    task automatic send_beat(logic func, logic [7:0] b);
        int unsigned gap;
        gap = fast ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk);
        i_func = func;
        i_in_byte = b;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        frame_results_q.push_back(parse_beat(func, b));
        beats_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_stream_byte(logic [7:0] b);
        if (noise_on && $urandom_range(0, 24) == 0) send_beat(FUNC_FINISH, 8'($urandom()));
        send_beat(FUNC_DATA, b);
    endtask

    task automatic send_word(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            send_stream_byte(stream_little ? v[8 * i +: 8] : v[8 * (3 - i) +: 8]);
    endtask

    task automatic send_record(logic [31:0] len);
        send_word($urandom());
        send_word($urandom());
        send_word(len);
        send_word($urandom());
        repeat (len) send_stream_byte(8'($urandom()));
    endtask

    task automatic write_max(logic [31:0] v);
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        max_size = v;
    endtask

    task automatic test_finish_after_reset();
        send_beat(FUNC_FINISH, 8'hFF);
        send_beat(FUNC_FINISH, 8'h00);
    endtask

    task automatic test_magic_search();
        logic [31:0] words [4];
        logic [31:0] w;
        logic [31:0] magic;
        logic [7:0]  b;
        int unsigned seq_left;
        words = '{MAGIC_US_BE, MAGIC_US_LE, MAGIC_NS_BE, MAGIC_NS_LE};
        magic = words[$urandom_range(0, 3)];
        w = '0;
        seq_left = 0;
        noise_on = 1'b1;
        // land the magic word on the first byte past the search limit
        for (int i = 0; i < SRCH_LIMIT - 6; i++) begin
            if (i % 64 == 0) fast = $urandom_range(0, 1);
            if (seq_left == 0 && $urandom_range(0, 49) == 0) begin
                w = words[$urandom_range(0, 3)];
                seq_left = 3;
            end
            if (seq_left != 0) begin
                b = w[8 * seq_left +: 8];
                seq_left--;
            end else if ($urandom_range(0, 1)) begin
                b = words[$urandom_range(0, 3)][8 * $urandom_range(0, 3) +: 8];
            end else begin
                b = 8'($urandom());
            end
            if (is_magic({srch_win, b})) b ^= 8'h01;
            send_stream_byte(b);
        end
        noise_on = 1'b0;
        fast = 1'b0;
        repeat (3) send_stream_byte(8'h00);
        for (int k = 3; k >= 0; k--) send_stream_byte(magic[8 * k +: 8]);
    endtask

    task automatic test_file_header();
        logic [31:0] snap_len;
        snap_len = $urandom_range(0, 1) ? 32'($urandom_range(40, 200)) : 32'd0;
        send_stream_byte(8'($urandom()));
        send_stream_byte(8'($urandom()));
        send_beat(FUNC_FINISH, 8'($urandom()));
        send_stream_byte(8'($urandom()));
        send_stream_byte(8'($urandom()));
        repeat (8) send_stream_byte(8'($urandom()));
        send_word(snap_len);
        send_word($urandom());
    endtask

    task automatic test_record_edges();
        send_beat(FUNC_FINISH, 8'hFF);
        write_max(32'd0);
        send_record(32'd0);
        send_beat(FUNC_FINISH, 8'h00);
        write_max(32'd3);
        send_word(32'hFFFF_FFFF);
        send_beat(FUNC_FINISH, 8'hA5);
        send_word(32'h0);
        send_word(32'd3);
        send_word(32'hFFFF_FFFF);
        send_stream_byte(8'h00);
        send_beat(FUNC_FINISH, 8'h5A);
        send_stream_byte(8'hFF);
        send_stream_byte(8'h5A);
        write_max(32'hFFFF_FFFF);
        send_record(snap_q != 0 ? snap_q : 32'd1);
    endtask

    task automatic test_random_records();
        logic [31:0] settings [4];
        logic [31:0] allowed;
        logic [31:0] len;
        int unsigned start;
        settings = '{MAX_PKT_RESET, 32'hFFFF_FFFF, 32'($urandom_range(20, 300)), $urandom()};
        noise_on = 1'b1;
        start = beats_sent;
        for (int s = 0; s < 4; s++) begin
            write_max(settings[s]);
            allowed = (snap_q != 0 && snap_q < max_size) ? snap_q : max_size;
            while (beats_sent - start < (s + 1) * 100) begin
                if ($urandom_range(0, 14) == 0) fast = ~fast;
                case ($urandom_range(0, 9))
                    0: len = 32'd0;
                    1: len = (allowed <= 300) ? allowed : 32'($urandom_range(0, 300));
                    default: len = (allowed == 0) ? 32'd0 :
                                   32'($urandom_range(1, allowed < 40 ? allowed : 40));
                endcase
                send_record(len);
            end
        end
        noise_on = 1'b0;
        fast = 1'b0;
    endtask

    task automatic test_bad_length();
        logic [31:0] bad;
        logic [31:0] lim;
        if (snap_q != 0 && $urandom_range(0, 1)) begin
            write_max(32'hFFFF_FFFF);
            bad = snap_q + 1;
        end else begin
            lim = $urandom_range(0, 100);
            write_max(lim);
            bad = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : lim + 1;
        end
        send_word($urandom());
        send_word($urandom());
        send_word(bad);
        send_word($urandom());
        repeat (10) send_beat(FUNC_DATA, 8'($urandom()));
        send_beat(FUNC_FINISH, 8'($urandom()));
        send_beat(FUNC_DATA, 8'hFF);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_taken++;
            if (frame_results_q.size() == 0) begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: unexpected beat, expected none actual kind %0d",
                             $time, o_kind);
            end else begin
                head_result = frame_results_q.pop_front();
                check_field("kind", head_result.kind, o_kind);
                check_field("out_byte", head_result.out_byte, o_out_byte);
                check_field("error_code", head_result.error_code, o_error_code);
                check_field("little_endian", head_result.little_endian, o_little_endian);
                check_field("nanosecond", head_result.nanosecond, o_nanosecond);
                check_field("version", head_result.version, o_version);
                check_field("snap_length", head_result.snap_length, o_snap_length);
                check_field("link_type", head_result.link_type, o_link_type);
                check_field("ts_seconds", head_result.ts_seconds, o_ts_seconds);
                check_field("ts_fraction", head_result.ts_fraction, o_ts_fraction);
                check_field("included_length", head_result.included_length,
                            o_included_length);
                check_field("original_length", head_result.original_length,
                            o_original_length);
            end
        end
    end

    always @(negedge i_clk) begin
        if (results_taken != stall_seen) begin
            stall_seen = results_taken;
            stall_left = fast ? 0 : $urandom_range(0, 7);
        end
        i_out_stall = (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** pcap_stream_deframer_core: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_finish_after_reset();
        test_magic_search();
        test_file_header();
        test_record_edges();
        test_random_records();
        test_bad_length();
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && frame_results_q.size() == 0)
            $display("** pcap_stream_deframer_core: PASSED **");
        else
            $display("** pcap_stream_deframer_core: FAILED **");
        $finish;
    end

endmodule
